[src/ocab_pkg.sv]
// shared types and constants for the oriented cylinder bounding box block
package ocab_pkg;

   localparam int DIV_STEPS  = 60;
   localparam int SQRT_STEPS = 31;
   localparam int UNIT_BITS  = 30;

   // 1.0 squared in U1.60
   localparam logic [60:0] UNIT_SQ = 61'(1) << (2 * UNIT_BITS);
   localparam logic [62:0] ROUND_HALF = 63'(1) << UNIT_BITS;

   typedef struct packed {
      logic [2:0][31:0] center;
      logic [30:0]      height;
      logic [30:0]      diameter;
      logic             zero;
   } side_type;

endpackage

[src/oriented_cylinder_aabb.sv]
// top level: axis-aligned box of an oriented cylinder, fully pipelined
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  request  | start / busy       | req_center_*, req_axis_*, req_cone_height,
//           |                    | req_cone_diameter
//  response | rsp_valid (strobe) | rsp_min_*, rsp_max_*, rsp_zero_axis
//
// one word is accepted every cycle; busy is never raised
// each result passes through 98 register stages,
// 61 of them in the divider and 32 in the square root
// reset clears only the valid bits of the pipeline
// the receiver cannot stall, so the pipeline never holds
module oriented_cylinder_aabb
   import ocab_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic [30:0]        req_cone_height,
   input  logic [30:0]        req_cone_diameter,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_min_x,
   output logic signed [31:0] rsp_min_y,
   output logic signed [31:0] rsp_min_z,
   output logic signed [31:0] rsp_max_x,
   output logic signed [31:0] rsp_max_y,
   output logic signed [31:0] rsp_max_z,
   output logic               rsp_zero_axis
);

   localparam int SIDE_DEPTH = DIV_STEPS + SQRT_STEPS + 5;
   localparam int TAP_MUL    = DIV_STEPS + SQRT_STEPS + 2;
   localparam int LATENCY    = SIDE_DEPTH + 2;

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic accept;
   assign accept = start && !busy;
   assign busy   = 1'b0;

   // stage 1: magnitudes squared
   logic [2:0][31:0] axis_w;
   logic [2:0][31:0] mag_w;
   logic [2:0][63:0] sq1_ff;
   side_type         side1_ff;
   logic             vld1_ff;

   assign axis_w = {req_axis_z, req_axis_y, req_axis_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_w[k] = axis_w[k][31] ? 32'(-axis_w[k]) : axis_w[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= accept;
      end
      for (int k = 0; k < 3; k++) begin
         sq1_ff[k] <= 64'(mag_w[k]) * 64'(mag_w[k]);
      end
      side1_ff.center   <= {req_center_z, req_center_y, req_center_x};
      side1_ff.height   <= req_cone_height;
      side1_ff.diameter <= req_cone_diameter;
      side1_ff.zero     <= (req_axis_x == '0) && (req_axis_y == '0) && (req_axis_z == '0);
   end

   // stage 2: squared length
   logic [2:0][63:0] sq2_ff;
   logic [63:0]      sum_ff;

   always_ff @(posedge clock) begin
      sq2_ff <= sq1_ff;
      sum_ff <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
   end

   // side data and valid bits ride a delay line past the divider and root
   side_type side_ff[0:SIDE_DEPTH-1];
   logic     vld_ff [0:SIDE_DEPTH-1];

   always_ff @(posedge clock) begin
      side_ff[0] <= side1_ff;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i < SIDE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= vld1_ff;
         for (int i = 1; i < SIDE_DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   logic [2:0][30:0] n_w;
   logic [2:0][30:0] s_w;

   for (genvar k = 0; k < 3; k++) begin : g_axis
      logic [60:0] t_w;
      logic [60:0] rest_w;

      ocab_div u_div (
         .clock (clock),
         .num   (sq2_ff[k]),
         .den   (sum_ff),
         .quo   (t_w)
      );

      assign rest_w = UNIT_SQ - t_w;

      ocab_sqrt u_sqrt_n (
         .clock (clock),
         .rad   (t_w),
         .root  (n_w[k])
      );

      ocab_sqrt u_sqrt_s (
         .clock (clock),
         .rad   (rest_w),
         .root  (s_w[k])
      );
   end

   // products, then rounded half extent
   logic [2:0][61:0] ph_ff;
   logic [2:0][61:0] pd_ff;
   logic [2:0][31:0] ext_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ph_ff[k] <= 62'(side_ff[TAP_MUL].height) * 62'(n_w[k]);
         pd_ff[k] <= 62'(side_ff[TAP_MUL].diameter) * 62'(s_w[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (side_ff[TAP_MUL+1].zero) begin
            ext_ff[k] <= '0;
         end else begin
            ext_ff[k] <= 32'((63'(ph_ff[k]) + 63'(pd_ff[k]) + ROUND_HALF) >> (UNIT_BITS + 1));
         end
      end
   end

   // output register with saturation
   logic             rsp_valid_ff;
   logic [2:0][31:0] min_ff;
   logic [2:0][31:0] max_ff;
   logic             zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[SIDE_DEPTH-1];
      end
      for (int k = 0; k < 3; k++) begin
         min_ff[k] <= sat32(34'(signed'(side_ff[SIDE_DEPTH-1].center[k]))
                            - signed'({2'b00, ext_ff[k]}));
         max_ff[k] <= sat32(34'(signed'(side_ff[SIDE_DEPTH-1].center[k]))
                            + signed'({2'b00, ext_ff[k]}));
      end
      zero_ff <= side_ff[SIDE_DEPTH-1].zero;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_x     = min_ff[0];
   assign rsp_min_y     = min_ff[1];
   assign rsp_min_z     = min_ff[2];
   assign rsp_max_x     = max_ff[0];
   assign rsp_max_y     = max_ff[1];
   assign rsp_max_z     = max_ff[2];
   assign rsp_zero_axis = zero_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without a request at the pipeline latency");

   a_zero_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_axis |-> rsp_min_x == rsp_max_x && rsp_min_y == rsp_max_y
                                     && rsp_min_z == rsp_max_z)
      else $error("zero axis box not collapsed");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_x <= rsp_max_x && rsp_min_y <= rsp_max_y
                    && rsp_min_z <= rsp_max_z)
      else $error("box corners out of order");

endmodule

[src/ocab_div.sv]
// pipelined restoring divider giving floor(num * 2^60 / den) for num <= den
module ocab_div
   import ocab_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [60:0] quo
);

   logic [63:0] r_ff   [0:DIV_STEPS];
   logic [63:0] den_ff [0:DIV_STEPS];
   logic [59:0] q_ff   [0:DIV_STEPS];
   logic        full_ff[0:DIV_STEPS];

   always_ff @(posedge clock) begin
      r_ff[0]    <= num;
      den_ff[0]  <= den;
      q_ff[0]    <= '0;
      full_ff[0] <= (num >= den);
   end

   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
      logic [64:0] shift_in;
      logic        take_in;
      logic [63:0] r_in;
      logic [59:0] q_in;

      always_comb begin
         shift_in = {r_ff[i-1], 1'b0};
         take_in  = (shift_in >= {1'b0, den_ff[i-1]});
         r_in     = take_in ? 64'(shift_in - {1'b0, den_ff[i-1]}) : shift_in[63:0];
         q_in     = {q_ff[i-1][58:0], take_in};
      end

      always_ff @(posedge clock) begin
         r_ff[i]    <= r_in;
         den_ff[i]  <= den_ff[i-1];
         q_ff[i]    <= q_in;
         full_ff[i] <= full_ff[i-1];
      end
   end

   assign quo = full_ff[DIV_STEPS] ? UNIT_SQ : {1'b0, q_ff[DIV_STEPS]};

endmodule

[src/ocab_sqrt.sv]
// pipelined integer square root of a U1.60 radicand, one result bit per stage
module ocab_sqrt
   import ocab_pkg::*;
(
   input  logic        clock,
   input  logic [60:0] rad,
   output logic [30:0] root
);

   logic [61:0] v_ff  [0:SQRT_STEPS];
   logic [61:0] res_ff[0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      v_ff[0]   <= {1'b0, rad};
      res_ff[0] <= '0;
   end

   for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (62 - 2 * j);
      logic [61:0] trial_in;
      logic [61:0] v_in;
      logic [61:0] res_in;

      always_comb begin
         trial_in = res_ff[j-1] + BIT;
         if (v_ff[j-1] >= trial_in) begin
            v_in   = v_ff[j-1] - trial_in;
            res_in = (res_ff[j-1] >> 1) + BIT;
         end else begin
            v_in   = v_ff[j-1];
            res_in = res_ff[j-1] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[j]   <= v_in;
         res_ff[j] <= res_in;
      end
   end

   assign root = res_ff[SQRT_STEPS][30:0];

endmodule
